>>> src/word_vm_processor_core_assert.svh
// Assertion macros for the word VM core.
`ifndef WORD_VM_PROCESSOR_CORE_ASSERT_SVH
`define WORD_VM_PROCESSOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WVM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("wvm assertion failed");
`define WVM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("wvm assertion failed");
`else
`define WVM_ASSERT(lbl, clk, rstn, prop)
`define WVM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/wvm_pkg.sv
package wvm_pkg;

    localparam int ADDR_W    = 15;
    localparam int WORD_W    = 16;
    localparam int MEM_WORDS = 1 << ADDR_W;
    localparam int NUM_INSTR = 22;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_SET  = 5'd1;
    localparam logic [4:0] OP_PUSH = 5'd2;
    localparam logic [4:0] OP_POP  = 5'd3;
    localparam logic [4:0] OP_EQ   = 5'd4;
    localparam logic [4:0] OP_GT   = 5'd5;
    localparam logic [4:0] OP_JMP  = 5'd6;
    localparam logic [4:0] OP_JT   = 5'd7;
    localparam logic [4:0] OP_JF   = 5'd8;
    localparam logic [4:0] OP_ADD  = 5'd9;
    localparam logic [4:0] OP_MULT = 5'd10;
    localparam logic [4:0] OP_MOD  = 5'd11;
    localparam logic [4:0] OP_AND  = 5'd12;
    localparam logic [4:0] OP_OR   = 5'd13;
    localparam logic [4:0] OP_NOT  = 5'd14;
    localparam logic [4:0] OP_RMEM = 5'd15;
    localparam logic [4:0] OP_WMEM = 5'd16;
    localparam logic [4:0] OP_CALL = 5'd17;
    localparam logic [4:0] OP_RET  = 5'd18;
    localparam logic [4:0] OP_OUT  = 5'd19;
    localparam logic [4:0] OP_IN   = 5'd20;
    localparam logic [4:0] OP_NOOP = 5'd21;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    localparam logic ITEM_LOAD = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OPC, S_OPND, S_EXEC,
        S_RMEM, S_POP, S_RET, S_DIV, S_WB, S_DONE
    } wvm_state_t;

    typedef struct packed {
        logic        opcode;
        logic [14:0] address;
        logic [15:0] data;
        logic [7:0]  in_char;
    } wvm_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic [7:0]  out_char;
        logic        char_taken;
        logic [14:0] next_pc;
        logic [4:0]  instr_code;
    } wvm_out_t;

    function automatic logic [1:0] op_operands(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM: n = 2'd2;
            OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN: n = 2'd1;
            OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: n = 2'd3;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic op_has_dest(input logic [4:0] op);
        logic d;
        case (op)
            OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD,
            OP_AND, OP_OR, OP_NOT, OP_RMEM, OP_IN: d = 1'b1;
            default: d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

>>> src/wvm_ram.sv
module wvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/word_vm_processor_core.sv
// Word VM core: 32768 x 16-bit memory, eight registers, call/data stack.
// Input channel s_*: each item either loads one memory word (opcode 0) or
// executes one instruction (opcode 1); in_char is offered to an in instruction.
// Result channel m_*: exactly one item per input item, in order, carrying the
// status, any emitted character, whether in_char was taken, the new pc and
// the instruction number.
// After reset the core sweeps all 32768 main memory words to zero, one word per
// cycle; s_ready stays low until the sweep is done.
// Sequence: a load, or an execute while not running, goes straight to the result;
// an execute fetches the opcode, then each operand, then executes; rmem, mult, and
// pop or ret with a non-empty stack pass through a further state, and mod with a
// nonzero divisor a 16-step remainder loop first. Items are taken one at a time;
// the single memory port serializes opcode and operand fetches.
// A result waits in the output register while m_ready is low; the next item
// can still be accepted and runs up to its own result, which then waits.
// Reset clears registers, stack count, pc and status.
`include "word_vm_processor_core_assert.svh"

module word_vm_processor_core
    import wvm_pkg::*;
#(
    parameter int STACK_DEPTH = 1024
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wvm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wvm_out_t m_data
);

    localparam int SAW = $clog2(STACK_DEPTH);

    wvm_state_t       state_reg, state_next;
    logic [14:0]      clr_reg, clr_next;
    wvm_in_t          in_reg, in_next;
    logic [14:0]      pc_reg, pc_next;
    logic [1:0]       status_reg, status_next;
    logic [SAW:0]     sc_reg, sc_next;
    logic [15:0]      regs_reg [8];
    logic [15:0]      regs_next [8];
    logic [4:0]       op_reg, op_next;
    logic [1:0]       n_reg, n_next;
    logic [1:0]       idx_reg, idx_next;
    logic [2:0]       d_reg, d_next;
    logic [15:0]      val_reg [3];
    logic [15:0]      val_next [3];
    wvm_out_t         res_reg, res_next;
    wvm_out_t         m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;
    logic [14:0]      prod_reg, prod_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dvd_reg, dvd_next;
    logic [3:0]       cnt_reg, cnt_next;

    logic [14:0]      mem_addr;
    logic             mem_we;
    logic [15:0]      mem_wdata, mem_rdata;
    logic [SAW-1:0]   stk_addr;
    logic             stk_we;
    logic [15:0]      stk_wdata, stk_rdata;

    logic             accept, out_free, op_bad, raw_lit, raw_isreg, opnd_dest;
    logic             opnd_fault, last_opnd, stk_full, stk_empty;
    logic [15:0]      raw_val, x, y;
    logic [16:0]      rem_sh;
    logic [31:0]      prod_full;
    logic [14:0]      seq_pc;

    wvm_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_main_ram (
        .aclk  (aclk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    wvm_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .addr  (stk_addr),
        .we    (stk_we),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign op_bad    = (mem_rdata > 16'(NUM_INSTR - 1));
    assign raw_lit   = !mem_rdata[15];
    assign raw_isreg = mem_rdata[15] && (mem_rdata[14:3] == 12'd0);
    assign opnd_dest = (idx_reg == 2'd0) && op_has_dest(op_reg);
    assign opnd_fault = opnd_dest ? !raw_isreg : !(raw_lit || raw_isreg);
    assign raw_val   = raw_lit ? mem_rdata : regs_reg[mem_rdata[2:0]];
    assign last_opnd = (idx_reg == n_reg - 2'd1);
    assign stk_full  = (sc_reg == (SAW+1)'(STACK_DEPTH));
    assign stk_empty = (sc_reg == '0);
    assign x         = val_reg[1];
    assign y         = val_reg[2];
    assign rem_sh    = {rem_reg, dvd_reg[15]};
    assign prod_full = x * y;
    assign seq_pc    = pc_reg + 15'd1 + 15'(n_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == '1) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == ITEM_LOAD || status_reg != ST_RUN) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_OPC;
                    end
                end
            end
            S_OPC: begin
                if (op_bad) state_next = S_DONE;
                else if (op_operands(mem_rdata[4:0]) == 2'd0) state_next = S_EXEC;
                else state_next = S_OPND;
            end
            S_OPND: begin
                if (opnd_fault) state_next = S_DONE;
                else if (last_opnd) state_next = S_EXEC;
            end
            S_EXEC: begin
                case (op_reg)
                    OP_RMEM: state_next = S_RMEM;
                    OP_POP:  state_next = stk_empty ? S_DONE : S_POP;
                    OP_RET:  state_next = stk_empty ? S_DONE : S_RET;
                    OP_MULT: state_next = S_WB;
                    OP_MOD:  state_next = (y == 16'd0) ? S_DONE : S_DIV;
                    default: state_next = S_DONE;
                endcase
            end
            S_RMEM, S_POP, S_RET, S_WB: state_next = S_DONE;
            S_DIV: begin
                if (cnt_reg == 4'd0) state_next = S_WB;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        clr_next     = clr_reg;
        in_next      = in_reg;
        pc_next      = pc_reg;
        status_next  = status_reg;
        sc_next      = sc_reg;
        regs_next    = regs_reg;
        op_next      = op_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        d_next       = d_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        cnt_next     = cnt_reg;
        mem_addr     = pc_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        stk_addr     = sc_reg[SAW-1:0];
        stk_we       = 1'b0;
        stk_wdata    = '0;

        case (state_reg)
            S_CLEAR: begin
                mem_addr = clr_reg;
                mem_we   = 1'b1;
                clr_next = clr_reg + 15'd1;
            end
            S_IDLE: begin
                if (accept) begin
                    in_next  = s_data;
                    res_next = '{status: status_reg, out_valid: 1'b0, out_char: 8'd0,
                                 char_taken: 1'b0, next_pc: pc_reg, instr_code: 5'd0};
                    if (s_data.opcode == ITEM_LOAD) begin
                        mem_addr  = s_data.address;
                        mem_we    = 1'b1;
                        mem_wdata = s_data.data;
                    end
                end
            end
            S_OPC: begin
                if (op_bad) begin
                    status_next    = ST_FAULT;
                    res_next.status = ST_FAULT;
                end else begin
                    op_next  = mem_rdata[4:0];
                    n_next   = op_operands(mem_rdata[4:0]);
                    idx_next = 2'd0;
                    mem_addr = pc_reg + 15'd1;
                end
            end
            S_OPND: begin
                if (opnd_fault) begin
                    status_next         = ST_FAULT;
                    res_next.status     = ST_FAULT;
                    res_next.instr_code = op_reg;
                end else begin
                    if (opnd_dest) d_next = mem_rdata[2:0];
                    else val_next[idx_reg] = raw_val;
                    if (!last_opnd) begin
                        idx_next = idx_reg + 2'd1;
                        mem_addr = pc_reg + 15'd2 + 15'(idx_reg);
                    end
                end
            end
            S_EXEC: begin
                res_next.instr_code = op_reg;
                pc_next = seq_pc;
                case (op_reg)
                    OP_HALT: status_next = ST_HALT;
                    OP_SET:  regs_next[d_reg] = x;
                    OP_PUSH: begin
                        if (stk_full) status_next = ST_FAULT;
                        else begin
                            stk_we    = 1'b1;
                            stk_wdata = val_reg[0];
                            sc_next   = sc_reg + 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (stk_empty) status_next = ST_FAULT;
                        else begin
                            sc_next  = sc_reg - 1'b1;
                            stk_addr = sc_next[SAW-1:0];
                        end
                    end
                    OP_EQ:   regs_next[d_reg] = {15'd0, x == y};
                    OP_GT:   regs_next[d_reg] = {15'd0, x > y};
                    OP_JMP:  pc_next = val_reg[0][14:0];
                    OP_JT:   if (val_reg[0] != 16'd0) pc_next = x[14:0];
                    OP_JF:   if (val_reg[0] == 16'd0) pc_next = x[14:0];
                    OP_ADD:  regs_next[d_reg] = {1'b0, x[14:0] + y[14:0]};
                    OP_MULT: prod_next = prod_full[14:0];
                    OP_MOD: begin
                        if (y == 16'd0) status_next = ST_FAULT;
                        else begin
                            rem_next = '0;
                            dvd_next = x;
                            cnt_next = 4'd15;
                        end
                    end
                    OP_AND:  regs_next[d_reg] = {1'b0, x[14:0] & y[14:0]};
                    OP_OR:   regs_next[d_reg] = {1'b0, x[14:0] | y[14:0]};
                    OP_NOT:  regs_next[d_reg] = {1'b0, ~x[14:0]};
                    OP_RMEM: mem_addr = x[14:0];
                    OP_WMEM: begin
                        mem_addr  = val_reg[0][14:0];
                        mem_we    = 1'b1;
                        mem_wdata = x;
                    end
                    OP_CALL: begin
                        if (stk_full) status_next = ST_FAULT;
                        else begin
                            stk_we    = 1'b1;
                            stk_wdata = {1'b0, seq_pc};
                            sc_next   = sc_reg + 1'b1;
                            pc_next   = val_reg[0][14:0];
                        end
                    end
                    OP_RET: begin
                        if (stk_empty) status_next = ST_HALT;
                        else begin
                            sc_next  = sc_reg - 1'b1;
                            stk_addr = sc_next[SAW-1:0];
                        end
                    end
                    OP_OUT: begin
                        res_next.out_valid = 1'b1;
                        res_next.out_char  = val_reg[0][7:0];
                    end
                    OP_IN: begin
                        regs_next[d_reg]    = {8'd0, in_reg.in_char};
                        res_next.char_taken = 1'b1;
                    end
                    default: ;
                endcase
                if (status_next == ST_FAULT) pc_next = pc_reg;
                res_next.status  = status_next;
                res_next.next_pc = pc_next;
            end
            S_RMEM: regs_next[d_reg] = mem_rdata;
            S_POP:  regs_next[d_reg] = stk_rdata;
            S_RET: begin
                pc_next          = stk_rdata[14:0];
                res_next.next_pc = stk_rdata[14:0];
            end
            S_DIV: begin
                dvd_next = {dvd_reg[14:0], 1'b0};
                if (rem_sh >= {1'b0, y}) rem_next = 16'(rem_sh - {1'b0, y});
                else rem_next = rem_sh[15:0];
                cnt_next = cnt_reg - 4'd1;
            end
            S_WB: begin
                regs_next[d_reg] = (op_reg == OP_MOD) ? {1'b0, rem_reg[14:0]}
                                                      : {1'b0, prod_reg};
            end
            S_DONE: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pc_reg      <= '0;
            status_reg  <= ST_RUN;
            sc_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) regs_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pc_reg      <= pc_next;
            status_reg  <= status_next;
            sc_reg      <= sc_next;
            m_valid_reg <= m_valid_next;
            regs_reg    <= regs_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        op_reg     <= op_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        d_reg      <= d_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        cnt_reg    <= cnt_next;
    end

    `WVM_ASSERT(a_accept_leaves_idle, aclk, aresetn, accept |=> state_reg != S_IDLE)
    `WVM_ASSERT(a_stack_bound, aclk, aresetn, sc_reg <= (SAW+1)'(STACK_DEPTH))
    `WVM_ASSERT(a_status_code, aclk, aresetn, status_reg != 2'd3)
    `WVM_ASSERT(a_result_from_done, aclk, aresetn,
                $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)

endmodule

>>> bench/word_vm_processor_core_tb.sv
module word_vm_processor_core_tb;
    import wvm_pkg::*;

    localparam int DEPTH     = 16;
    localparam int LIMIT     = 3_000_000;
    localparam int RAND_ITEMS = 1030;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    wvm_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    wvm_out_t m_data;

    word_vm_processor_core #(.STACK_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // shadow machine state
    logic [15:0] vmem [MEM_WORDS];
    logic [15:0] vreg [8];
    logic [15:0] vstack [DEPTH];
    int          vsp;
    logic [14:0] vpc;
    logic [1:0]  vstat;

    wvm_out_t    expected_results[$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          cycles;
    int          idle_pct;
    int          hold_tag;
    int          hold_seen;
    int          hold_left;
    int          term_case;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic int arg_count(input logic [4:0] op);
        case (op)
            OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM: return 2;
            OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN: return 1;
            OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic wvm_out_t vm_step(input wvm_in_t it);
        wvm_out_t    r;
        logic [15:0] opw;
        logic [15:0] w;
        logic [15:0] v [3];
        logic [31:0] wide;
        logic [4:0]  op;
        logic [2:0]  d;
        logic [14:0] pc;
        logic [14:0] nxt;
        logic        bad;
        int          n;
        r = '0;
        if (it.opcode == ITEM_LOAD) begin
            vmem[it.address] = it.data;
        end else if (vstat == ST_RUN) begin
            pc = vpc;
            opw = vmem[pc];
            if (opw >= NUM_INSTR) begin
                vstat = ST_FAULT;
            end else begin
                op = opw[4:0];
                n = arg_count(op);
                bad = 1'b0;
                d = '0;
                v = '{default: '0};
                for (int i = 0; i < n; i++) begin
                    w = vmem[pc + 15'(1 + i)];
                    if (i == 0 && op inside {OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT,
                            OP_MOD, OP_AND, OP_OR, OP_NOT, OP_RMEM, OP_IN}) begin
                        if (w[15:3] != 13'h1000) bad = 1'b1;
                        else d = w[2:0];
                    end else if (!w[15]) begin
                        v[i] = w;
                    end else if (w[15:3] == 13'h1000) begin
                        v[i] = vreg[w[2:0]];
                    end else begin
                        bad = 1'b1;
                    end
                end
                r.instr_code = op;
                if (bad) begin
                    vstat = ST_FAULT;
                end else begin
                    nxt = pc + 15'(1 + n);
                    case (op)
                        OP_HALT: vstat = ST_HALT;
                        OP_SET:  vreg[d] = v[1];
                        OP_PUSH: begin
                            if (vsp >= DEPTH) vstat = ST_FAULT;
                            else begin vstack[vsp] = v[0]; vsp++; end
                        end
                        OP_POP: begin
                            if (vsp == 0) vstat = ST_FAULT;
                            else begin vsp--; vreg[d] = vstack[vsp]; end
                        end
                        OP_EQ:   vreg[d] = 16'(v[1] == v[2]);
                        OP_GT:   vreg[d] = 16'(v[1] > v[2]);
                        OP_JMP:  nxt = v[0][14:0];
                        OP_JT:   if (v[0] != 0) nxt = v[1][14:0];
                        OP_JF:   if (v[0] == 0) nxt = v[1][14:0];
                        OP_ADD: begin
                            wide = 32'(v[1]) + 32'(v[2]);
                            vreg[d] = {1'b0, wide[14:0]};
                        end
                        OP_MULT: begin
                            wide = 32'(v[1]) * 32'(v[2]);
                            vreg[d] = {1'b0, wide[14:0]};
                        end
                        OP_MOD: begin
                            if (v[2] == 0) vstat = ST_FAULT;
                            else begin
                                wide = 32'(v[1] % v[2]);
                                vreg[d] = {1'b0, wide[14:0]};
                            end
                        end
                        OP_AND:  vreg[d] = {1'b0, v[1][14:0] & v[2][14:0]};
                        OP_OR:   vreg[d] = {1'b0, v[1][14:0] | v[2][14:0]};
                        OP_NOT:  vreg[d] = {1'b0, ~v[1][14:0]};
                        OP_RMEM: vreg[d] = vmem[v[1][14:0]];
                        OP_WMEM: vmem[v[0][14:0]] = v[1];
                        OP_CALL: begin
                            if (vsp >= DEPTH) vstat = ST_FAULT;
                            else begin
                                vstack[vsp] = {1'b0, nxt};
                                vsp++;
                                nxt = v[0][14:0];
                            end
                        end
                        OP_RET: begin
                            if (vsp == 0) vstat = ST_HALT;
                            else begin vsp--; nxt = vstack[vsp][14:0]; end
                        end
                        OP_OUT: begin
                            r.out_valid = 1'b1;
                            r.out_char = v[0][7:0];
                        end
                        OP_IN: begin
                            vreg[d] = {8'd0, it.in_char};
                            r.char_taken = 1'b1;
                        end
                        default: ;
                    endcase
                    if (vstat != ST_FAULT) vpc = nxt;
                end
            end
        end
        r.status = vstat;
        r.next_pc = vpc;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        wvm_out_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                e = expected_results.pop_front();
                if (m_data.status !== e.status)
                    report_mismatch($sformatf("status %0d exp %0d", m_data.status, e.status));
                if (m_data.out_valid !== e.out_valid)
                    report_mismatch($sformatf("out_valid %0b exp %0b",
                        m_data.out_valid, e.out_valid));
                if (m_data.out_char !== e.out_char)
                    report_mismatch($sformatf("out_char %0d exp %0d",
                        m_data.out_char, e.out_char));
                if (m_data.char_taken !== e.char_taken)
                    report_mismatch($sformatf("char_taken %0b exp %0b",
                        m_data.char_taken, e.char_taken));
                if (m_data.next_pc !== e.next_pc)
                    report_mismatch($sformatf("next_pc %0d exp %0d",
                        m_data.next_pc, e.next_pc));
                if (m_data.instr_code !== e.instr_code)
                    report_mismatch($sformatf("instr_code %0d exp %0d",
                        m_data.instr_code, e.instr_code));
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_item(input wvm_in_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(vm_step(it));
        items_sent++;
    endtask

    task automatic load_word(input logic [14:0] addr, input logic [15:0] word);
        send_item('{ITEM_LOAD, addr, word, 8'($urandom)});
    endtask

    task automatic exec_step(input logic [7:0] ch);
        send_item('{~ITEM_LOAD, 15'($urandom), 16'($urandom), ch});
    endtask

    // place an instruction at the current pc and execute it
    task automatic run_op(input logic [15:0] opw, input logic [15:0] a, b, c,
                          input logic [7:0] ch);
        logic [15:0] ws [4];
        int          n;
        ws = '{opw, a, b, c};
        n = (opw < NUM_INSTR) ? arg_count(opw[4:0]) : 0;
        for (int i = 0; i <= n; i++) load_word(vpc + 15'(i), ws[i]);
        exec_step(ch);
    endtask

    function automatic logic [15:0] reg_ref(input int r);
        return 16'(MEM_WORDS + r);
    endfunction

    function automatic logic [15:0] rand_src();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, MEM_WORDS - 1));
            6: return $urandom_range(1) ? 16'd0 : 16'(MEM_WORDS - 1);
            default: return reg_ref($urandom_range(7));
        endcase
    endfunction

    function automatic logic [15:0] src_value(input logic [15:0] w);
        return w[15] ? vreg[w[2:0]] : w;
    endfunction

    task automatic drain_stack();
        while (vsp > 0) run_op(OP_POP, reg_ref($urandom_range(7)), 0, 0, 0);
    endtask

    task automatic rand_instr();
        logic [4:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        op = 5'($urandom_range(1, NUM_INSTR - 1));
        if ((op == OP_POP || op == OP_RET) && vsp == 0) op = OP_PUSH;
        if ((op == OP_PUSH || op == OP_CALL) && vsp >= DEPTH) op = OP_POP;
        a = rand_src();
        if (op inside {OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD,
                OP_AND, OP_OR, OP_NOT, OP_RMEM, OP_IN})
            a = reg_ref($urandom_range(7));
        b = rand_src();
        c = rand_src();
        if (op == OP_MOD && src_value(c) == 0) c = 16'($urandom_range(1, MEM_WORDS - 1));
        run_op(op, a, b, c, 8'($urandom));
    endtask

    task automatic test_arith_edges();
        run_op(OP_SET, reg_ref(0), 16'(MEM_WORDS - 1), 0, 0);
        run_op(OP_ADD, reg_ref(1), reg_ref(0), 16'd1, 0);
        run_op(OP_MULT, reg_ref(2), reg_ref(0), reg_ref(0), 0);
        run_op(OP_NOT, reg_ref(3), 16'd0, 0, 0);
        run_op(OP_MOD, reg_ref(4), reg_ref(0), 16'd3, 0);
        run_op(OP_EQ, reg_ref(5), reg_ref(1), 16'd0, 0);
        run_op(OP_GT, reg_ref(6), reg_ref(0), reg_ref(3), 0);
        run_op(OP_AND, reg_ref(7), reg_ref(0), 16'h2aaa, 0);
        run_op(OP_OR, reg_ref(7), reg_ref(7), 16'h1555, 0);
    endtask

    task automatic test_memory_and_wrap();
        load_word(15'd200, 16'hffff);
        run_op(OP_RMEM, reg_ref(5), 16'd200, 0, 0);
        run_op(OP_WMEM, 16'd300, reg_ref(5), 0, 0);
        run_op(OP_RMEM, reg_ref(6), 16'd300, 0, 0);
        // wide register as jump target lands at the top word, fetch wraps
        run_op(OP_JMP, reg_ref(5), 0, 0, 0);
        run_op(OP_ADD, reg_ref(1), reg_ref(5), reg_ref(5), 0);
        run_op(OP_NOOP, 0, 0, 0, 0);
    endtask

    task automatic test_io_and_flow();
        run_op(OP_OUT, 16'(MEM_WORDS - 1), 0, 0, 0);
        run_op(OP_OUT, reg_ref(3), 0, 0, 0);
        run_op(OP_IN, reg_ref(2), 0, 0, 8'd0);
        run_op(OP_IN, reg_ref(2), 0, 0, 8'd255);
        run_op(OP_JT, 16'd0, 16'd500, 0, 0);
        run_op(OP_JT, 16'd1, 16'd500, 0, 0);
        run_op(OP_JF, 16'd1, 16'd900, 0, 0);
        run_op(OP_JF, 16'd0, 16'd900, 0, 0);
        run_op(OP_CALL, 16'd4000, 0, 0, 0);
        run_op(OP_PUSH, reg_ref(5), 0, 0, 0);
        run_op(OP_POP, reg_ref(4), 0, 0, 0);
        run_op(OP_RET, 0, 0, 0, 0);
    endtask

    task automatic test_random_programs();
        int stop;
        stop = items_sent + RAND_ITEMS;
        while (items_sent < stop) begin
            if ($urandom_range(9) == 0)
                load_word(15'($urandom), 16'($urandom));
            else
                rand_instr();
        end
    endtask

    task automatic test_no_idle_stretch();
        idle_pct = 0;
        repeat (60) rand_instr();
        idle_pct = 23;
    endtask

    task automatic test_backpressure();
        hold_tag++;
        repeat (30) rand_instr();
    endtask

    task automatic test_stop_conditions();
        term_case = $urandom_range(7);
        case (term_case)
            0: run_op(OP_HALT, 0, 0, 0, 0);
            1: begin drain_stack(); run_op(OP_RET, 0, 0, 0, 0); end
            2: run_op(16'($urandom_range(NUM_INSTR, 65535)), 0, 0, 0, 0);
            3: run_op(OP_ADD, reg_ref(1), 16'($urandom_range(MEM_WORDS + 8, 65535)), 0, 0);
            4: run_op(OP_SET, $urandom_range(1) ? 16'($urandom_range(0, MEM_WORDS - 1))
                                                : 16'($urandom_range(MEM_WORDS + 8, 65535)),
                      16'd1, 0, 0);
            5: begin drain_stack(); run_op(OP_POP, reg_ref(0), 0, 0, 0); end
            6: run_op(OP_MOD, reg_ref(2), 16'd5, 16'd0, 0);
            default: begin
                while (vsp < DEPTH) run_op(OP_PUSH, rand_src(), 0, 0, 0);
                run_op(OP_PUSH, 16'd7, 0, 0, 0);
            end
        endcase
        repeat (4) exec_step(8'($urandom));
        repeat (4) load_word(15'($urandom), 16'($urandom));
        run_op(OP_NOOP, 0, 0, 0, 0);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        cycles = 0;
        idle_pct = 23;
        hold_tag = 0;
        hold_seen = 0;
        hold_left = 0;
        for (int i = 0; i < MEM_WORDS; i++) vmem[i] = '0;
        for (int i = 0; i < 8; i++) vreg[i] = '0;
        vsp = 0;
        vpc = '0;
        vstat = ST_RUN;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_arith_edges();
        test_memory_and_wrap();
        test_io_and_flow();
        test_random_programs();
        test_no_idle_stretch();
        test_backpressure();
        test_stop_conditions();

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("%0d items sent, %0d results checked; arithmetic, memory, stack, flow",
                 items_sent, results_seen);
        $display("and I/O instructions with random operands, stalls, a long hold-off;");
        $display("stop case %0d exercised", term_case);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
